@@ rtl/spq_pkg.sv @@
// Shared types, constants and codes of the sorted priority queue with skip.
package spq_pkg;

  localparam int DEPTH = 64;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EW    = 33;

  localparam logic [3:0] CMD_CLEAR     = 4'd0;
  localparam logic [3:0] CMD_INSERT    = 4'd1;
  localparam logic [3:0] CMD_INS_HIGH  = 4'd2;
  localparam logic [3:0] CMD_INS_LOW   = 4'd3;
  localparam logic [3:0] CMD_PEEK_TOP  = 4'd4;
  localparam logic [3:0] CMD_PEEK_CUR  = 4'd5;
  localparam logic [3:0] CMD_SKIP      = 4'd6;
  localparam logic [3:0] CMD_POP_TOP   = 4'd7;
  localparam logic [3:0] CMD_POP_CUR   = 4'd8;
  localparam logic [3:0] CMD_RMV_TYPE  = 4'd9;
  localparam logic [3:0] CMD_CNT_TYPE  = 4'd10;
  localparam logic [3:0] CMD_CONTAINS  = 4'd11;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  localparam logic [9:0] SPACING_RST = 10'd10;

  typedef struct packed {
    logic               blocking;
    logic signed [15:0] prio;
    logic        [15:0] etype;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic walk;
    logic finish;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic need_walk;
    logic walk_done;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/spq_ram.sv @@
// Generic single write, single read RAM with registered read data.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/spq_ctrl.sv @@
// Command sequencer: accept, set up, walk the store if needed, deliver the result.
module spq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  spq_pkg::stat_t stat,
  output spq_pkg::ctrl_t ctrl
);
  import spq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SETUP  = 4'b0010,
    S_WALK   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_SETUP;
      S_SETUP:  state_nxt = stat.need_walk ? S_WALK : S_FINISH;
      S_WALK:   if (stat.walk_done) state_nxt = S_FINISH;
      S_FINISH: if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  always_comb begin
    ctrl.load   = (state_r == S_IDLE) && in_tvalid;
    ctrl.setup  = (state_r == S_SETUP);
    ctrl.walk   = (state_r == S_WALK);
    ctrl.finish = (state_r == S_FINISH) && stat.out_free;
  end

endmodule

@@ rtl/spq_datapath.sv @@
// Queue state, store walker and result register.
module spq_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [39:0]    in_tdata,
  input  logic           cfg_we,
  input  logic [9:0]     cfg_wdata,
  input  spq_pkg::ctrl_t ctrl,
  output spq_pkg::stat_t stat,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [55:0]    out_tdata
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    W_INS, W_POP, W_RMV, W_CNT, W_ONE
  } walk_t;

  // latched command
  logic [3:0]         cmd_r;
  logic [15:0]        ityp_r;
  logic signed [15:0] iprio_r;
  logic               iblk_r;

  // queue state
  logic [CW-1:0]      cnt_r;
  logic [IW-1:0]      skip_r;
  logic signed [15:0] hi_r, lo_r;
  logic [9:0]         spacing_r;

  // walk state
  logic signed [15:0] p_r;
  logic               front_r;
  logic [1:0]         st_r;
  walk_t              mode_r;
  logic               iss_r, up_r, rv_r;
  logic [IW-1:0]      rptr_r, end_r, ridx_r, pos_r;
  logic [CW-1:0]      acc_r, n_r;
  logic signed [15:0] hp_r;
  entry_t             item_r;

  // result register
  logic               ov_r;
  logic [55:0]        od_r;

  // store port
  logic               we, re;
  logic [IW-1:0]      waddr, raddr;
  entry_t             wdata, rd;
  logic [EW-1:0]      rdata;

  assign rd = entry_t'(rdata);

  spq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // relative priorities, saturated
  logic signed [16:0] sum_hi, dif_lo;
  logic signed [15:0] p_hi, p_lo, p_calc;
  always_comb begin
    sum_hi = {hi_r[15], hi_r} + $signed({7'd0, spacing_r});
    dif_lo = {lo_r[15], lo_r} - $signed({7'd0, spacing_r});
    p_hi = (sum_hi[16] != sum_hi[15]) ? (sum_hi[16] ? 16'sh8000 : 16'sh7fff)
                                      : sum_hi[15:0];
    p_lo = (dif_lo[16] != dif_lo[15]) ? (dif_lo[16] ? 16'sh8000 : 16'sh7fff)
                                      : dif_lo[15:0];
    case (cmd_r)
      CMD_INS_HIGH: p_calc = p_hi;
      CMD_INS_LOW:  p_calc = p_lo;
      default:      p_calc = iprio_r;
    endcase
  end

  logic is_ins;
  assign is_ins = (cmd_r == CMD_INSERT) || (cmd_r == CMD_INS_HIGH) ||
                  (cmd_r == CMD_INS_LOW);

  // set-up decode
  logic               empty, full, cur_ok, skip_ok, s_walk, s_front;
  logic [IW-1:0]      top_idx, cur_idx, s_start, s_end, s_pos;
  logic [1:0]         s_st;
  walk_t              s_mode;
  logic signed [15:0] lo_eff;
  always_comb begin
    empty   = (cnt_r == '0);
    full    = (cnt_r == CW'(DEPTH));
    top_idx = IW'(cnt_r - CW'(1));
    cur_idx = IW'(cnt_r - CW'(1) - CW'(skip_r));
    cur_ok  = CW'(skip_r) < cnt_r;
    skip_ok = ((CW+1)'(skip_r) + (CW+1)'(1)) < (CW+1)'(cnt_r);
    lo_eff  = empty ? p_calc : lo_r;
    s_front = (p_calc <= lo_eff);
    s_walk  = 1'b0;
    s_mode  = W_ONE;
    s_start = top_idx;
    s_end   = top_idx;
    s_pos   = '0;
    s_st    = ST_OK;
    case (cmd_r)
      CMD_INSERT, CMD_INS_HIGH, CMD_INS_LOW: begin
        if (full) begin
          s_st = ST_FULL;
        end else if (!empty) begin
          s_walk = 1'b1;
          s_mode = W_INS;
          s_end  = '0;
        end
      end
      CMD_PEEK_TOP: begin
        if (empty) s_st = ST_EMPTY;
        else s_walk = 1'b1;
      end
      CMD_PEEK_CUR: begin
        if (!cur_ok) begin
          s_st = ST_EMPTY;
        end else begin
          s_walk  = 1'b1;
          s_start = cur_idx;
          s_end   = cur_idx;
        end
      end
      CMD_SKIP: begin
        if (!skip_ok) begin
          s_st = ST_REFUSED;
        end else begin
          s_walk  = 1'b1;
          s_start = cur_idx;
          s_end   = cur_idx;
        end
      end
      CMD_POP_TOP, CMD_POP_CUR: begin
        s_pos = (cmd_r == CMD_POP_TOP) ? top_idx : cur_idx;
        if ((cmd_r == CMD_POP_TOP) ? empty : !cur_ok) begin
          s_st = ST_EMPTY;
        end else begin
          s_walk  = 1'b1;
          s_mode  = W_POP;
          // start one below a top pop to pick up the new top priority
          s_start = (s_pos == top_idx && s_pos != '0) ? s_pos - IW'(1) : s_pos;
        end
      end
      CMD_RMV_TYPE, CMD_CNT_TYPE, CMD_CONTAINS: begin
        if (!empty) begin
          s_walk  = 1'b1;
          s_mode  = (cmd_r == CMD_RMV_TYPE) ? W_RMV : W_CNT;
          s_start = '0;
        end
      end
      default: s_walk = 1'b0;
    endcase
  end

  // arrivals from the store during the walk
  logic arr, stop, match;
  always_comb begin
    arr   = ctrl.walk && rv_r;
    match = (rd.etype == ityp_r);
    stop  = (mode_r == W_INS) && !front_r && (rd.prio <= p_r);
    re    = ctrl.walk && iss_r;
    raddr = rptr_r;
    we    = 1'b0;
    waddr = '0;
    wdata = rd;
    if (arr) begin
      case (mode_r)
        W_INS: begin
          we    = !stop;
          waddr = ridx_r + IW'(1);
        end
        W_POP: begin
          we    = (ridx_r > pos_r);
          waddr = ridx_r - IW'(1);
        end
        W_RMV: begin
          we    = !match;
          waddr = IW'(n_r);
        end
        default: we = 1'b0;
      endcase
    end
    if (ctrl.finish && is_ins && st_r == ST_OK) begin
      we    = 1'b1;
      waddr = pos_r;
      wdata = '{blocking: iblk_r, prio: p_r, etype: ityp_r};
    end
  end

  assign stat.need_walk = s_walk;
  assign stat.walk_done = arr && (stop || ridx_r == end_r);
  assign stat.out_free  = !ov_r || out_tready;

  // final values of the command
  logic [CW-1:0]      cnt_f, cnt_m1;
  logic [IW-1:0]      skip_f;
  logic signed [15:0] hi_f, lo_f;
  logic [1:0]         st_f;
  entry_t             oi_f;
  logic [6:0]         tc_f;
  logic               fd_f;
  always_comb begin
    cnt_m1 = cnt_r - CW'(1);
    cnt_f  = cnt_r;
    skip_f = skip_r;
    hi_f   = hi_r;
    lo_f   = lo_r;
    st_f   = st_r;
    oi_f   = '0;
    tc_f   = '0;
    fd_f   = 1'b0;
    case (cmd_r)
      CMD_CLEAR: begin
        cnt_f = '0;
        hi_f  = '0;
        lo_f  = '0;
      end
      CMD_INSERT, CMD_INS_HIGH, CMD_INS_LOW: begin
        if (st_r == ST_OK) begin
          cnt_f = cnt_r + CW'(1);
          hi_f  = (p_r > hi_r) ? p_r : hi_r;
          lo_f  = (p_r < lo_r) ? p_r : lo_r;
          oi_f  = '{blocking: iblk_r, prio: p_r, etype: ityp_r};
        end
      end
      CMD_PEEK_TOP, CMD_PEEK_CUR: begin
        if (st_r == ST_OK) oi_f = item_r;
      end
      CMD_SKIP: begin
        if (st_r == ST_OK && !item_r.blocking) skip_f = skip_r + IW'(1);
        else st_f = ST_REFUSED;
      end
      CMD_POP_TOP, CMD_POP_CUR: begin
        if (st_r == ST_OK) begin
          oi_f  = item_r;
          cnt_f = cnt_m1;
          hi_f  = (cnt_m1 == '0) ? 16'sd0 : hp_r;
          lo_f  = (cnt_m1 == '0) ? 16'sd0 : lo_r;
        end
      end
      CMD_RMV_TYPE: begin
        cnt_f = n_r;
        tc_f  = 7'(acc_r);
      end
      CMD_CNT_TYPE: tc_f = 7'(acc_r);
      CMD_CONTAINS: fd_f = (acc_r != '0);
      default: cnt_f = cnt_r;
    endcase
  end

  // queue state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      skip_r    <= '0;
      hi_r      <= '0;
      lo_r      <= '0;
      spacing_r <= SPACING_RST;
      ov_r      <= 1'b0;
      iss_r     <= 1'b0;
      rv_r      <= 1'b0;
    end else begin
      if (cfg_we) spacing_r <= cfg_wdata;
      // take the command
      if (ctrl.load) begin
        cmd_r   <= in_tdata[3:0];
        ityp_r  <= in_tdata[19:4];
        iprio_r <= in_tdata[35:20];
        iblk_r  <= in_tdata[36];
      end
      // set up the walk
      if (ctrl.setup) begin
        p_r     <= p_calc;
        front_r <= s_front;
        st_r    <= s_st;
        mode_r  <= s_mode;
        iss_r   <= s_walk;
        up_r    <= (s_mode != W_INS);
        rptr_r  <= s_start;
        end_r   <= s_end;
        pos_r   <= s_pos;
        acc_r   <= '0;
        n_r     <= '0;
        rv_r    <= 1'b0;
        if (cmd_r == CMD_PEEK_TOP) skip_r <= '0;
        if (is_ins && empty) begin
          hi_r <= p_calc;
          lo_r <= p_calc;
        end
      end
      // issue reads, one per cycle; stop issuing once the walk is done
      if (ctrl.walk) begin
        ridx_r <= rptr_r;
        if (stat.walk_done) begin
          iss_r <= 1'b0;
          rv_r  <= 1'b0;
        end else begin
          rv_r <= iss_r;
          if (iss_r) begin
            if (rptr_r == end_r) iss_r <= 1'b0;
            else rptr_r <= up_r ? rptr_r + IW'(1) : rptr_r - IW'(1);
          end
        end
      end
      // process arrivals
      if (arr) begin
        case (mode_r)
          W_INS: begin
            if (stop) pos_r <= ridx_r + IW'(1);
            else if (ridx_r == '0) pos_r <= '0;
          end
          W_POP: begin
            if (ridx_r == pos_r) item_r <= rd;
            else hp_r <= rd.prio;
          end
          W_RMV: begin
            if (match) acc_r <= acc_r + CW'(1);
            else n_r <= n_r + CW'(1);
          end
          W_CNT: if (match) acc_r <= acc_r + CW'(1);
          default: item_r <= rd;
        endcase
      end
      // commit and present the result
      if (ctrl.finish) begin
        cnt_r  <= cnt_f;
        skip_r <= skip_f;
        hi_r   <= hi_f;
        lo_r   <= lo_f;
        ov_r   <= 1'b1;
        od_r   <= {6'd0, 7'(cnt_f), fd_f, tc_f, oi_f.blocking, oi_f.prio,
                   oi_f.etype, st_f};
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

endmodule

@@ rtl/sorted_priority_queue_with_skip_core.sv @@
// Sorted priority queue with skip: top level.
// One command is handled at a time and gives one result transfer. A command
// either reads no store entry or reads the store one entry per cycle: peeks and
// skips read one entry, inserts walk down from the top until the insertion
// point, pops shift the entries above the removed one, and remove, count and
// contains scan all entries. A stalled result holds up the finish of the
// command that follows it. The walk is set by the single read and single write
// port of the entry store. The next command is taken while a result still waits
// on the output register.
module sorted_priority_queue_with_skip_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // command[3:0], item_type, item_priority, item_blocking
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // status[1:0], out_type, out_priority, out_blocking,
                                  // type_count, type_found, occupancy
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata   // priority_spacing
);
  import spq_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  spq_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ rtl/spq_checker.sv @@
// Port-level checks of the queue, bound to the top level.
module spq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  import spq_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command taken while busy");

  // occupancy within depth
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[49:43] <= 7'(DEPTH))
    else $error("occupancy beyond depth");

  // full only at depth
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_FULL |-> out_tdata[49:43] == 7'(DEPTH))
    else $error("full reported below depth");

endmodule

bind sorted_priority_queue_with_skip_core spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/sorted_priority_queue_with_skip_core_test.sv @@
// Testbench for the sorted priority queue with skip: directed and random stimulus checked against a predictor.
module sorted_priority_queue_with_skip_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int RUN_LIMIT = 600000;
  localparam int DRAIN_WAIT = 80;

  typedef struct {
    logic [1:0]         status;
    logic [15:0]        rtype;
    logic signed [15:0] rprio;
    logic               rblk;
    logic [6:0]         tcount;
    logic               found;
    logic [6:0]         occ;
  } answer_t;

  // Queue model: predicts one answer per accepted command and checks it
  class queue_scoreboard;
    logic [15:0] etype[DEPTH];
    int          eprio[DEPTH];
    logic        eblk[DEPTH];
    int          count, skip, highest, lowest, spacing;
    answer_t     awaited[$];
    int          errors, mismatches;

    function new();
      count = 0; skip = 0; highest = 0; lowest = 0; spacing = SPACING_RST;
      errors = 0; mismatches = 0;
    endfunction

    function int sat(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void show(int pos, ref answer_t a);
      a.rtype = etype[pos];
      a.rprio = 16'(eprio[pos]);
      a.rblk = eblk[pos];
    endfunction

    function void insert(logic [15:0] t, int p, logic b, ref answer_t a);
      int pos;
      if (count >= DEPTH) begin
        a.status = ST_FULL;
        return;
      end
      if (count == 0) begin
        highest = p;
        lowest = p;
      end
      pos = 0;
      if (p > lowest) begin
        while (pos < count && eprio[pos] <= p) pos++;
      end
      for (int i = count; i > pos; i--) begin
        etype[i] = etype[i-1]; eprio[i] = eprio[i-1]; eblk[i] = eblk[i-1];
      end
      etype[pos] = t; eprio[pos] = p; eblk[pos] = b;
      count++;
      if (p > highest) highest = p;
      if (p < lowest) lowest = p;
      show(pos, a);
    endfunction

    function void remove(int pos, ref answer_t a);
      show(pos, a);
      for (int i = pos; i + 1 < count; i++) begin
        etype[i] = etype[i+1]; eprio[i] = eprio[i+1]; eblk[i] = eblk[i+1];
      end
      count--;
      if (count == 0) begin
        highest = 0;
        lowest = 0;
      end else begin
        highest = eprio[count-1];
      end
    endfunction

    // Work out the answer of one accepted command
    function void note_command(logic [3:0] cmd, logic [15:0] t, logic signed [15:0] p,
                               logic b);
      answer_t a;
      int n;
      a = '{default: '0};
      case (cmd)
        CMD_CLEAR: begin
          count = 0; highest = 0; lowest = 0;
        end
        CMD_INSERT:   insert(t, p, b, a);
        CMD_INS_HIGH: insert(t, sat(highest + spacing), b, a);
        CMD_INS_LOW:  insert(t, sat(lowest - spacing), b, a);
        CMD_PEEK_TOP: begin
          skip = 0;
          if (count == 0) a.status = ST_EMPTY;
          else show(count - 1, a);
        end
        CMD_PEEK_CUR: begin
          if (skip >= count) a.status = ST_EMPTY;
          else show(count - 1 - skip, a);
        end
        CMD_SKIP: begin
          if (count > skip + 1 && !eblk[count-1-skip]) skip++;
          else a.status = ST_REFUSED;
        end
        CMD_POP_TOP: begin
          if (count == 0) a.status = ST_EMPTY;
          else remove(count - 1, a);
        end
        CMD_POP_CUR: begin
          if (skip >= count) a.status = ST_EMPTY;
          else remove(count - 1 - skip, a);
        end
        CMD_RMV_TYPE: begin
          n = 0;
          for (int i = 0; i < count; i++) begin
            if (etype[i] != t) begin
              etype[n] = etype[i]; eprio[n] = eprio[i]; eblk[n] = eblk[i];
              n++;
            end
          end
          a.tcount = 7'(count - n);
          count = n;
        end
        CMD_CNT_TYPE: begin
          n = 0;
          for (int i = 0; i < count; i++) if (etype[i] == t) n++;
          a.tcount = 7'(n);
        end
        CMD_CONTAINS: begin
          for (int i = 0; i < count; i++) if (etype[i] == t) a.found = 1'b1;
        end
        default: ;
      endcase
      a.occ = 7'(count);
      awaited = {awaited, a};
    endfunction

    // Compare one result transfer with the oldest awaited answer
    function void check_result(answer_t got);
      answer_t w;
      if (awaited.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result transfer: status %0d occ %0d",
                                        got.status, got.occ);
        return;
      end
      w = awaited.pop_front();
      if (got.status !== w.status || got.rtype !== w.rtype || got.rprio !== w.rprio ||
          got.rblk !== w.rblk || got.tcount !== w.tcount || got.found !== w.found ||
          got.occ !== w.occ) begin
        errors++;
        if (mismatches++ < 10)
          $display("mismatch: exp st %0d ty %h pr %0d bl %0d cnt %0d fd %0d occ %0d | got st %0d ty %h pr %0d bl %0d cnt %0d fd %0d occ %0d",
                   w.status, w.rtype, w.rprio, w.rblk, w.tcount, w.found, w.occ,
                   got.status, got.rtype, got.rprio, got.rblk, got.tcount, got.found,
                   got.occ);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_wdata = '0;

  queue_scoreboard sb = new();
  bit hold_request = 1'b0;
  int cycles = 0;

  sorted_priority_queue_with_skip_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    answer_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[1:0];
      got.rtype  = out_tdata[17:2];
      got.rprio  = out_tdata[33:18];
      got.rblk   = out_tdata[34];
      got.tcount = out_tdata[41:35];
      got.found  = out_tdata[42];
      got.occ    = out_tdata[49:43];
      sb.check_result(got);
    end
  end

  // Receiver: a stall pattern chosen anew at the start of each phase, plus long holds on request
  initial begin
    int mode;
    int phase;
    mode = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_request = 1'b0;
      end
      if (phase == 0) mode = $urandom_range(0, 3);
      phase = (phase + 1) % 64;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= phase[0];
        2: out_tready <= ($urandom_range(0, 1) == 1);
        default: out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  int burst_left = 0;

  // Offer one command and hold it until the transfer
  task automatic send(logic [3:0] cmd, logic [15:0] t, logic signed [15:0] p, logic b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, b, p, t, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, t, p, b);
  endtask

  // Lower valid, let the block drain, then write the spacing register
  task automatic set_spacing(logic [9:0] value);
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.spacing = value;
  endtask

  // One random command; fill biases towards inserts, drain towards removals
  task automatic random_command(int mode);
    logic [3:0] cmd;
    logic [15:0] t;
    logic signed [15:0] p;
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == 1 && roll < 70) cmd = 4'($urandom_range(CMD_INSERT, CMD_INS_LOW));
    else if (mode == 2 && roll < 50) cmd = (roll < 25) ? CMD_POP_TOP : CMD_POP_CUR;
    else if (roll < 2) cmd = 4'($urandom_range(12, 15));
    else if (roll < 4) cmd = CMD_CLEAR;
    else if (roll < 35) cmd = 4'($urandom_range(CMD_INSERT, CMD_INS_LOW));
    else cmd = 4'($urandom_range(CMD_PEEK_TOP, CMD_CONTAINS));
    t = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    p = ($urandom_range(0, 1) == 0) ? 16'($signed($urandom_range(0, 40)) - 20)
                                    : 16'($urandom);
    send(cmd, t, p, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-queue cases, extremes, saturation, ties, skip rules
    send(CMD_PEEK_TOP, 16'h0000, 16'sd0, 1'b0);
    send(CMD_PEEK_CUR, 16'h0000, 16'sd0, 1'b0);
    send(CMD_POP_TOP, 16'h0000, 16'sd0, 1'b0);
    send(CMD_POP_CUR, 16'h0000, 16'sd0, 1'b0);
    send(CMD_SKIP, 16'h0000, 16'sd0, 1'b0);
    send(CMD_INSERT, 16'hffff, 16'sh7fff, 1'b1);
    send(CMD_INS_HIGH, 16'h0001, 16'sd0, 1'b0);
    send(CMD_INSERT, 16'h0002, -16'sd32768, 1'b0);
    send(CMD_INS_LOW, 16'h0003, 16'sd0, 1'b1);
    send(CMD_INSERT, 16'h0004, 16'sd5, 1'b0);
    send(CMD_INSERT, 16'h0005, 16'sd5, 1'b0);
    send(CMD_SKIP, 16'h0000, 16'sd0, 1'b0);
    send(CMD_SKIP, 16'h0000, 16'sd0, 1'b0);
    send(CMD_PEEK_CUR, 16'h0000, 16'sd0, 1'b0);
    send(CMD_POP_CUR, 16'h0000, 16'sd0, 1'b0);
    send(CMD_PEEK_TOP, 16'h0000, 16'sd0, 1'b0);
    send(CMD_SKIP, 16'h0000, 16'sd0, 1'b0);
    send(CMD_CNT_TYPE, 16'h0004, 16'sd0, 1'b0);
    send(CMD_CONTAINS, 16'hffff, 16'sd0, 1'b0);
    send(CMD_CONTAINS, 16'h1234, 16'sd0, 1'b0);
    send(CMD_RMV_TYPE, 16'h0004, 16'sd0, 1'b0);
    send(4'd15, 16'hffff, -16'sd1, 1'b1);
    send(CMD_POP_TOP, 16'h0000, 16'sd0, 1'b0);
    send(CMD_CLEAR, 16'h0000, 16'sd0, 1'b0);

    // Random phases over several spacings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_spacing(10'd0);
        1: set_spacing(10'd1023);
        2: set_spacing(10'd1);
        default: set_spacing(10'($urandom));
      endcase
      if (ph == 2) hold_request = 1'b1;
      for (int k = 0; k < 200; k++) begin
        random_command((k < 100) ? ((ph % 2) ? 1 : 0) : ((ph == 1) ? 2 : 0));
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
